@@ sv/ctb_pkg.sv @@
// ----------------------------------------------------------------------------
// ctb_pkg
// Shared sizes, request codes and controller/datapath interface types for the
// countdown timer bank.
// ----------------------------------------------------------------------------
`default_nettype none

package ctb_pkg;

    // bank geometry
    localparam int MAX_SLOTS  = 16;
    localparam int SLOT_BITS  = $clog2(MAX_SLOTS);
    localparam int COUNT_BITS = $clog2(MAX_SLOTS + 1);
    localparam int TIME_BITS  = 32;

    // request field widths
    localparam int REQ_BITS   = 3;
    localparam int SVAL_BITS  = 31;
    localparam int DELTA_BITS = 16;
    localparam int NCNT_BITS  = 5;

    // request codes
    localparam logic [REQ_BITS-1:0] REQ_TICK   = 3'd0;
    localparam logic [REQ_BITS-1:0] REQ_START  = 3'd1;
    localparam logic [REQ_BITS-1:0] REQ_STOP   = 3'd2;
    localparam logic [REQ_BITS-1:0] REQ_QUERY  = 3'd3;
    localparam logic [REQ_BITS-1:0] REQ_REMOVE = 3'd4;
    localparam logic [REQ_BITS-1:0] REQ_RESIZE = 3'd5;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;          // capture the incoming request
        logic decode;        // check index, set up sweep counters, apply resize count
        logic tick_step;     // age one slot
        logic compact_step;  // move one slot during remove
        logic clear_step;    // clear one slot above the count
        logic finish;        // single-slot update and result capture
    } ctb_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic [REQ_BITS-1:0] req;
        logic                bad;
        logic                tick_last;
        logic                compact_done;
        logic                clear_done;
    } ctb_stat_t;

endpackage

`default_nettype wire

@@ sv/ctb_datapath.sv @@
// ----------------------------------------------------------------------------
// ctb_datapath
// Timer storage, running flags, slot count, sweep counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ctb_datapath
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire ctb_pkg::ctb_cmd_t                     cmd,
    output      ctb_pkg::ctb_stat_t                    stat,
    input  wire logic [ctb_pkg::REQ_BITS-1:0]          req_type,
    input  wire logic [ctb_pkg::SLOT_BITS-1:0]         slot,
    input  wire logic [ctb_pkg::SVAL_BITS-1:0]         start_value,
    input  wire logic [ctb_pkg::DELTA_BITS-1:0]        delta,
    input  wire logic [ctb_pkg::NCNT_BITS-1:0]         new_count,
    output      logic                                  timed_out,
    output      logic                                  is_running,
    output      logic signed [ctb_pkg::TIME_BITS-1:0]  time_left,
    output      logic [ctb_pkg::COUNT_BITS-1:0]        slots_in_use,
    output      logic                                  bad_index
);

    localparam int T = ctb_pkg::TIME_BITS;
    localparam logic [T-1:0] TIME_MIN = {1'b1, {(T-1){1'b0}}};
    localparam logic [ctb_pkg::COUNT_BITS-1:0] MAX_CNT =
        ctb_pkg::COUNT_BITS'(ctb_pkg::MAX_SLOTS);

    // timer state
    logic [T-1:0]                     rem_reg [ctb_pkg::MAX_SLOTS];
    logic [ctb_pkg::MAX_SLOTS-1:0]    run_reg;
    logic [ctb_pkg::COUNT_BITS-1:0]   count_reg;
    logic [ctb_pkg::COUNT_BITS-1:0]   idx_reg;
    logic [ctb_pkg::COUNT_BITS-1:0]   wr_reg;

    // latched request
    logic [ctb_pkg::REQ_BITS-1:0]     req_reg;
    logic [ctb_pkg::SLOT_BITS-1:0]    slot_reg;
    logic [ctb_pkg::SVAL_BITS-1:0]    sval_reg;
    logic [ctb_pkg::DELTA_BITS-1:0]   delta_reg;
    logic [ctb_pkg::NCNT_BITS-1:0]    ncount_reg;

    // result register
    logic                             timed_out_reg;
    logic                             is_running_reg;
    logic [T-1:0]                     time_left_reg;
    logic [ctb_pkg::COUNT_BITS-1:0]   slots_reg;
    logic                             bad_reg;

    logic [ctb_pkg::SLOT_BITS-1:0]    rd_idx;
    logic [ctb_pkg::SLOT_BITS-1:0]    wr_idx;
    logic [T-1:0]                     rd_rem;
    logic                             rd_run;
    logic                             expired;
    logic [T:0]                       diff;
    logic [T-1:0]                     tick_val;
    logic                             needs_slot;
    logic                             bad;
    logic [ctb_pkg::COUNT_BITS-1:0]   ncl;
    logic                             compact_done;
    logic                             is_query;
    logic                             hi_running;

    // single read port: the request slot at finish, else the sweep index
    assign rd_idx  = cmd.finish ? slot_reg : idx_reg[ctb_pkg::SLOT_BITS-1:0];
    assign wr_idx  = wr_reg[ctb_pkg::SLOT_BITS-1:0];
    assign rd_rem  = rem_reg[rd_idx];
    assign rd_run  = run_reg[rd_idx];
    assign expired = rd_run && (rd_rem[T-1] || (rd_rem == '0));

    // saturating subtract toward the most negative time
    assign diff     = {rd_rem[T-1], rd_rem}
                    - {{(T + 1 - ctb_pkg::DELTA_BITS){1'b0}}, delta_reg};
    assign tick_val = (diff[T] != diff[T-1]) ? TIME_MIN : diff[T-1:0];

    // index check and resize clamp
    assign needs_slot = (req_reg == ctb_pkg::REQ_START) || (req_reg == ctb_pkg::REQ_STOP)
                     || (req_reg == ctb_pkg::REQ_QUERY);
    assign bad        = needs_slot
                     && ({{(ctb_pkg::COUNT_BITS-ctb_pkg::SLOT_BITS){1'b0}}, slot_reg}
                         >= count_reg);
    assign ncl        = (ctb_pkg::COUNT_BITS'(ncount_reg) > MAX_CNT)
                      ? MAX_CNT : ctb_pkg::COUNT_BITS'(ncount_reg);
    assign compact_done = (idx_reg >= count_reg);
    assign is_query   = (req_reg == ctb_pkg::REQ_QUERY) && !bad;

    // status to the controller
    always_comb
    begin
        stat.req          = req_reg;
        stat.bad          = bad;
        stat.tick_last    = (idx_reg == MAX_CNT - 1'b1);
        stat.compact_done = compact_done;
        stat.clear_done   = (idx_reg == MAX_CNT);
    end

    // request latch, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg    <= req_type;
            slot_reg   <= slot;
            sval_reg   <= start_value;
            delta_reg  <= delta;
            ncount_reg <= new_count;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            timed_out_reg  <= is_query && expired;
            is_running_reg <= is_query && rd_run;
            time_left_reg  <= is_query ? rd_rem : '0;
            slots_reg      <= count_reg;
            bad_reg        <= bad;
        end
    end

    // timer bank and sweep counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ctb_pkg::MAX_SLOTS; i++)
            begin
                rem_reg[i] <= '0;
            end
            run_reg   <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            wr_reg    <= '0;
        end
        else if (cmd.decode)
        begin
            idx_reg <= '0;
            wr_reg  <= '0;
            if (req_reg == ctb_pkg::REQ_RESIZE)
            begin
                count_reg <= ncl;
                idx_reg   <= ncl;
            end
        end
        else if (cmd.tick_step)
        begin
            if (rd_run)
            begin
                rem_reg[rd_idx] <= tick_val;
            end
            idx_reg <= idx_reg + 1'b1;
        end
        else if (cmd.compact_step)
        begin
            if (compact_done)
            begin
                count_reg <= wr_reg;
                idx_reg   <= wr_reg;
            end
            else
            begin
                if (!expired)
                begin
                    rem_reg[wr_idx] <= rd_rem;
                    run_reg[wr_idx] <= rd_run;
                    wr_reg          <= wr_reg + 1'b1;
                end
                idx_reg <= idx_reg + 1'b1;
            end
        end
        else if (cmd.clear_step)
        begin
            if (idx_reg != MAX_CNT)
            begin
                rem_reg[rd_idx] <= '0;
                run_reg[rd_idx] <= 1'b0;
                idx_reg         <= idx_reg + 1'b1;
            end
        end
        else if (cmd.finish && !bad)
        begin
            case (req_reg)
                ctb_pkg::REQ_START:
                begin
                    rem_reg[rd_idx] <= T'(sval_reg);
                    run_reg[rd_idx] <= 1'b1;
                end
                ctb_pkg::REQ_STOP:
                begin
                    rem_reg[rd_idx] <= '0;
                    run_reg[rd_idx] <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // outputs
    assign timed_out    = timed_out_reg;
    assign is_running   = is_running_reg;
    assign time_left    = time_left_reg;
    assign slots_in_use = slots_reg;
    assign bad_index    = bad_reg;

    // any running slot at or above the count
    always_comb
    begin
        hi_running = 1'b0;
        for (int i = 0; i < ctb_pkg::MAX_SLOTS; i++)
        begin
            if (ctb_pkg::COUNT_BITS'(i) >= count_reg)
            begin
                hi_running = hi_running | run_reg[i];
            end
        end
    end

    // count never exceeds the bank
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("slot count above bank size");

    // between requests no slot above the count is running
    a_hi_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !hi_running)
        else $error("running slot above count");

    // compaction write pointer never passes the read pointer
    a_wr_behind: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.compact_step |-> (wr_reg <= idx_reg))
        else $error("compaction pointer overrun");

endmodule

`default_nettype wire

@@ sv/ctb_ctrl.sv @@
// ----------------------------------------------------------------------------
// ctb_ctrl
// Request sequencer: accepts one request, steps the datapath sweeps and hands
// the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ctb_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output      logic                s_tready,
    output      logic                m_tvalid,
    input  wire logic                m_tready,
    output      ctb_pkg::ctb_cmd_t   cmd,
    input  wire ctb_pkg::ctb_stat_t  stat
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TICK,
        ST_COMPACT,
        ST_CLEAR,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    // next state and datapath commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.decode = 1'b1;
                if (stat.bad)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    case (stat.req)
                        ctb_pkg::REQ_TICK:   state_next = ST_TICK;
                        ctb_pkg::REQ_REMOVE: state_next = ST_COMPACT;
                        ctb_pkg::REQ_RESIZE: state_next = ST_CLEAR;
                        default:             state_next = ST_RESULT;
                    endcase
                end
            end
            ST_TICK:
            begin
                cmd.tick_step = 1'b1;
                if (stat.tick_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_COMPACT:
            begin
                cmd.compact_step = 1'b1;
                if (stat.compact_done)
                begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/countdown_timer_bank_top.sv @@
// ----------------------------------------------------------------------------
// countdown_timer_bank_top
// Bank of 16 signed 32-bit countdown timers with running flags and a slot count.
// ----------------------------------------------------------------------------
// One request is handled at a time and each gives one result. Start, stop,
// query, a bad index and unknown codes go from decode straight to the result.
// A tick walks all 16 slots one per cycle through the single timer port.
// Remove reads one slot per cycle up to the slot count, then clears the freed
// slots one per cycle.
// Resize clears the dropped slots one per cycle.
// The result sits in an output register, so the next request is accepted
// while a result still waits.
`default_nettype none

module countdown_timer_bank_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    // req_type[2:0], slot[6:3], start_value[37:7], delta[53:38], new_count[58:54]
    input  wire logic [63:0] s_tdata,
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    // timed_out[0], is_running[1], time_left[33:2], slots_in_use[38:34], bad_index[39]
    output      logic [39:0] m_tdata
);

    ctb_pkg::ctb_cmd_t   cmd;
    ctb_pkg::ctb_stat_t  stat;

    logic                                 timed_out;
    logic                                 is_running;
    logic signed [ctb_pkg::TIME_BITS-1:0] time_left;
    logic [ctb_pkg::COUNT_BITS-1:0]       slots_in_use;
    logic                                 bad_index;

    // request sequencer
    ctb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // timer storage and result
    ctb_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .req_type     (s_tdata[2:0]),
        .slot         (s_tdata[6:3]),
        .start_value  (s_tdata[37:7]),
        .delta        (s_tdata[53:38]),
        .new_count    (s_tdata[58:54]),
        .timed_out    (timed_out),
        .is_running   (is_running),
        .time_left    (time_left),
        .slots_in_use (slots_in_use),
        .bad_index    (bad_index)
    );

    // result packing
    assign m_tdata = {bad_index, slots_in_use, time_left, is_running, timed_out};

endmodule

`default_nettype wire

@@ bench/ctb_checker.sv @@
// ----------------------------------------------------------------------------
// ctb_checker
// Request/result scoreboard for the countdown timer bank.
// ----------------------------------------------------------------------------
// Watches both stream channels. Every accepted request is run through a
// local model of the timer bank and the expected result is queued. Every
// accepted result is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
`default_nettype none

module ctb_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    // req_type[2:0], slot[6:3], start_value[37:7], delta[53:38], new_count[58:54]
    input  wire logic [63:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    // timed_out[0], is_running[1], time_left[33:2], slots_in_use[38:34], bad_index[39]
    input  wire logic [39:0] m_tdata,
    output int               err_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // result layout, msb first, matches m_tdata
    typedef struct packed {
        logic                           bad_index;
        logic [ctb_pkg::COUNT_BITS-1:0] slots_in_use;
        logic signed [31:0]             time_left;
        logic                           is_running;
        logic                           timed_out;
    } timer_result_t;

    localparam longint TIME_LO = -(longint'(1) <<< (ctb_pkg::TIME_BITS - 1));
    localparam longint TIME_HI = -TIME_LO - 1;

    // local copy of the bank
    logic signed [ctb_pkg::TIME_BITS-1:0] timer_val [ctb_pkg::MAX_SLOTS];
    logic                                 timer_on  [ctb_pkg::MAX_SLOTS];
    int unsigned                          slot_count;

    timer_result_t expected_q [$];
    int            fails = 0;

    // drop a slot back to its idle value
    function automatic void clear_timer(input int unsigned idx);
        timer_val[idx] = '0;
        timer_on[idx]  = 1'b0;
    endfunction

    // apply one request to the bank and return the result it gives
    function automatic timer_result_t apply_request(input logic [63:0] word);
        logic [ctb_pkg::REQ_BITS-1:0] rq;
        int unsigned                  sl;
        int unsigned                  nc;
        int unsigned                  wr;
        longint                       sv;
        longint                       dl;
        timer_result_t                r;
        rq = word[2:0];
        sl = 32'(word[6:3]);
        sv = longint'(word[37:7]);
        dl = longint'(word[53:38]);
        nc = 32'(word[58:54]);
        r  = '0;
        if ((rq == ctb_pkg::REQ_START || rq == ctb_pkg::REQ_STOP
             || rq == ctb_pkg::REQ_QUERY) && sl >= slot_count)
        begin
            r.bad_index = 1'b1;
        end
        else
        begin
            case (rq)
                ctb_pkg::REQ_TICK:
                begin
                    // age running timers, saturating at the most negative time
                    for (int i = 0; i < slot_count && i < ctb_pkg::MAX_SLOTS; i++)
                    begin
                        if (timer_on[i])
                        begin
                            if (longint'(timer_val[i]) < TIME_LO + dl)
                                timer_val[i] = TIME_LO[ctb_pkg::TIME_BITS-1:0];
                            else
                                timer_val[i] = timer_val[i] - dl[ctb_pkg::TIME_BITS-1:0];
                        end
                    end
                end
                ctb_pkg::REQ_START:
                begin
                    if (sv > TIME_HI)
                        sv = TIME_HI;
                    timer_val[sl] = sv[ctb_pkg::TIME_BITS-1:0];
                    timer_on[sl]  = 1'b1;
                end
                ctb_pkg::REQ_STOP:
                    clear_timer(sl);
                ctb_pkg::REQ_QUERY:
                begin
                    r.is_running = timer_on[sl];
                    r.timed_out  = timer_on[sl] && (timer_val[sl] <= 0);
                    r.time_left  = timer_val[sl];
                end
                ctb_pkg::REQ_REMOVE:
                begin
                    // compact the survivors toward slot 0
                    wr = 0;
                    for (int i = 0; i < slot_count && i < ctb_pkg::MAX_SLOTS; i++)
                    begin
                        if (!(timer_on[i] && timer_val[i] <= 0))
                        begin
                            timer_val[wr] = timer_val[i];
                            timer_on[wr]  = timer_on[i];
                            wr++;
                        end
                    end
                    for (int i = int'(wr); i < ctb_pkg::MAX_SLOTS; i++)
                        clear_timer(i);
                    slot_count = wr;
                end
                ctb_pkg::REQ_RESIZE:
                begin
                    if (nc > ctb_pkg::MAX_SLOTS)
                        nc = ctb_pkg::MAX_SLOTS;
                    for (int i = int'(nc); i < ctb_pkg::MAX_SLOTS; i++)
                        clear_timer(i);
                    slot_count = nc;
                end
                default:
                    ;
            endcase
        end
        r.slots_in_use = ctb_pkg::COUNT_BITS'(slot_count);
        return r;
    endfunction

    // watch both channels
    always @(posedge clk or negedge rst_n)
    begin
        timer_result_t got;
        timer_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ctb_pkg::MAX_SLOTS; i++)
                clear_timer(i);
            slot_count = 0;
            expected_q.delete();
            pending <= 0;
        end
        else
        begin
            // results first: a request accepted now cannot answer in the same cycle
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_q.size() == 0)
                begin
                    $error("result %h with no request outstanding", m_tdata);
                    fails++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.timed_out !== want.timed_out)
                    begin
                        $error("timed_out: expected %0d, got %0d", want.timed_out, got.timed_out);
                        fails++;
                    end
                    if (got.is_running !== want.is_running)
                    begin
                        $error("is_running: expected %0d, got %0d",
                               want.is_running, got.is_running);
                        fails++;
                    end
                    if (got.time_left !== want.time_left)
                    begin
                        $error("time_left: expected %0d, got %0d", want.time_left, got.time_left);
                        fails++;
                    end
                    if (got.slots_in_use !== want.slots_in_use)
                    begin
                        $error("slots_in_use: expected %0d, got %0d",
                               want.slots_in_use, got.slots_in_use);
                        fails++;
                    end
                    if (got.bad_index !== want.bad_index)
                    begin
                        $error("bad_index: expected %0d, got %0d", want.bad_index, got.bad_index);
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(apply_request(s_tdata));
            pending   <= expected_q.size();
            err_count <= fails;
        end
    end

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the countdown timer bank.
// ----------------------------------------------------------------------------
// Drives a directed set of requests, then three random phases with different
// idle patterns on both sides, then a short run of full-size ticks on a
// cleared and a full timer. A checker instance predicts and compares results.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // codes the block does not decode
    localparam logic [ctb_pkg::REQ_BITS-1:0] REQ_UNDEF_A = 3'd6;
    localparam logic [ctb_pkg::REQ_BITS-1:0] REQ_UNDEF_B = 3'd7;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int LONG_HOLD       = 300;
    localparam int TAIL_CYCLES     = 60;
    localparam int PHASE_ITEMS     = 280;
    localparam int SAT_TICKS       = 24;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // req_type[2:0], slot[6:3], start_value[37:7], delta[53:38], new_count[58:54]
    logic [63:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // timed_out[0], is_running[1], time_left[33:2], slots_in_use[38:34], bad_index[39]
    logic [39:0] m_tdata;

    int   err_count;
    int   pending;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic hold_go     = 1'b0;

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    countdown_timer_bank_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ctb_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .err_count (err_count),
        .pending   (pending)
    );

    // result side: random stalls plus one long hold-off
    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_go && !hold_done)
            begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= (int'($urandom_range(0, 99)) >= rx_idle_pct);
            end
        end
    end

    // watchdog on cycles with no handshake
    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_CYCLES)
            begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    // offer one request after a random gap and wait for it to be taken
    task automatic put_req(input logic [ctb_pkg::REQ_BITS-1:0] rq, input logic [3:0] sl,
                           input logic [30:0] sv, input logic [15:0] dl,
                           input logic [4:0] nc);
        while (int'($urandom_range(0, 99)) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, nc, dl, sv, sl, rq};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // stop offering until every result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // one request of weighted random kind and content
    task automatic random_req();
        int                           pick;
        logic [ctb_pkg::REQ_BITS-1:0] rq;
        logic [30:0]                  sv;
        logic [15:0]                  dl;
        logic [4:0]                   nc;
        pick = int'($urandom_range(0, 99));
        if (pick < 25)
            rq = ctb_pkg::REQ_TICK;
        else if (pick < 50)
            rq = ctb_pkg::REQ_START;
        else if (pick < 58)
            rq = ctb_pkg::REQ_STOP;
        else if (pick < 80)
            rq = ctb_pkg::REQ_QUERY;
        else if (pick < 88)
            rq = ctb_pkg::REQ_REMOVE;
        else if (pick < 96)
            rq = ctb_pkg::REQ_RESIZE;
        else
            rq = pick[0] ? REQ_UNDEF_A : REQ_UNDEF_B;
        // mostly small start values so ticks bring timers to expiry
        case ($urandom_range(0, 9))
            0:       sv = '0;
            1:       sv = '1;
            2, 3:    sv = 31'($urandom);
            default: sv = 31'($urandom_range(0, 60000));
        endcase
        case ($urandom_range(0, 9))
            0:       dl = '0;
            1:       dl = '1;
            2:       dl = 16'($urandom);
            default: dl = 16'($urandom_range(0, 3000));
        endcase
        // keep the bank mostly well populated
        if ($urandom_range(0, 4) == 0)
            nc = 5'($urandom_range(0, 31));
        else
            nc = 5'($urandom_range(6, 16));
        put_req(rq, 4'($urandom_range(0, 15)), sv, dl, nc);
    endtask

    // main stimulus
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty bank: index checks and unknown codes
        put_req(ctb_pkg::REQ_QUERY, 4'd0, '0, '0, '0);
        put_req(ctb_pkg::REQ_START, 4'd15, '1, '0, '0);
        put_req(REQ_UNDEF_A, 4'hF, '1, '1, '1);
        put_req(REQ_UNDEF_B, 4'h0, '0, '0, '0);
        // oversized resize saturates to the full bank
        put_req(ctb_pkg::REQ_RESIZE, 4'd0, '0, '0, 5'd31);
        put_req(ctb_pkg::REQ_START, 4'd0, '1, '0, '0);
        put_req(ctb_pkg::REQ_START, 4'd15, '0, '0, '0);
        put_req(ctb_pkg::REQ_START, 4'd1, 31'd1, '0, '0);
        put_req(ctb_pkg::REQ_TICK, 4'd0, '0, 16'hFFFF, '0);
        put_req(ctb_pkg::REQ_TICK, 4'd0, '0, '0, '0);
        put_req(ctb_pkg::REQ_QUERY, 4'd0, '0, '0, '0);
        put_req(ctb_pkg::REQ_QUERY, 4'd15, '0, '0, '0);
        put_req(ctb_pkg::REQ_QUERY, 4'd1, '0, '0, '0);
        put_req(ctb_pkg::REQ_STOP, 4'd1, '0, '0, '0);
        put_req(ctb_pkg::REQ_QUERY, 4'd1, '0, '0, '0);
        put_req(ctb_pkg::REQ_REMOVE, 4'd0, '0, '0, '0);
        put_req(ctb_pkg::REQ_QUERY, 4'd14, '0, '0, '0);
        // shrink then grow exposes cleared slots
        put_req(ctb_pkg::REQ_RESIZE, 4'd0, '0, '0, 5'd4);
        put_req(ctb_pkg::REQ_RESIZE, 4'd0, '0, '0, 5'd10);
        put_req(ctb_pkg::REQ_QUERY, 4'd5, '0, '0, '0);
        put_req(ctb_pkg::REQ_QUERY, 4'd0, '0, '0, '0);
        put_req(ctb_pkg::REQ_RESIZE, 4'd0, '0, '0, 5'd0);
        put_req(ctb_pkg::REQ_TICK, 4'd0, '0, 16'd100, '0);
        put_req(ctb_pkg::REQ_REMOVE, 4'd0, '0, '0, '0);
        put_req(ctb_pkg::REQ_STOP, 4'd0, '0, '0, '0);
        wait_drained();

        // random phases: receiver idle more, then sender idle more, then neither idle
        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 54 : 0;
            rx_idle_pct <= (phase == 0) ? 54 : (phase == 1) ? 31 : 0;
            if (phase == 1)
                hold_go <= 1'b1;
            put_req(ctb_pkg::REQ_RESIZE, 4'd0, '0, '0, 5'd16);
            repeat (PHASE_ITEMS) random_req();
            wait_drained();
        end

        // full-size ticks on a cleared and a full timer
        put_req(ctb_pkg::REQ_RESIZE, 4'd0, '0, '0, 5'd2);
        put_req(ctb_pkg::REQ_START, 4'd0, '0, '0, '0);
        put_req(ctb_pkg::REQ_START, 4'd1, '1, '0, '0);
        repeat (SAT_TICKS) put_req(ctb_pkg::REQ_TICK, 4'd0, '0, 16'hFFFF, '0);
        put_req(ctb_pkg::REQ_QUERY, 4'd0, '0, '0, '0);
        put_req(ctb_pkg::REQ_QUERY, 4'd1, '0, '0, '0);
        put_req(ctb_pkg::REQ_TICK, 4'd0, '0, 16'd1, '0);
        put_req(ctb_pkg::REQ_QUERY, 4'd0, '0, '0, '0);
        put_req(ctb_pkg::REQ_REMOVE, 4'd0, '0, '0, '0);
        put_req(ctb_pkg::REQ_QUERY, 4'd0, '0, '0, '0);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0 && pending == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

`default_nettype wire

@@ countdown_timer_bank_top.f @@
sv/ctb_pkg.sv
sv/ctb_datapath.sv
sv/ctb_ctrl.sv
sv/countdown_timer_bank_top.sv
bench/ctb_checker.sv
bench/tb.sv
